// ----- hdl/fbc_pkg.sv -----
// shared constants and types for the feistel block cipher engine
package fbc_pkg;

    // round key table
    localparam int KEY_DEPTH = 8192;
    localparam int KEY_AW    = $clog2(KEY_DEPTH);

    // round count register
    localparam int          RC_W     = 14;
    localparam logic [13:0] RC_RESET = 14'(KEY_DEPTH);

    // field widths
    localparam int HALF_W  = 32;
    localparam int BLOCK_W = 2 * HALF_W;
    localparam int OP_W    = 2;
    localparam int IDX_W   = 13;

    // input word layout, lowest field first, padded to whole bytes
    localparam int S_DATA_W = 112;
    localparam int IDX_LSB  = 0;
    localparam int KEY_LSB  = IDX_LSB + IDX_W;
    localparam int HIGH_LSB = KEY_LSB + HALF_W;
    localparam int LOW_LSB  = HIGH_LSB + HALF_W;

    // operation codes carried in tuser
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_KEY = 2'd0,
        OP_ENCRYPT  = 2'd1,
        OP_DECRYPT  = 2'd2
    } t_op;

    // engine control states
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

endpackage

// ----- hdl/feistel_block_cipher_top.sv -----
// feistel block cipher engine: round key table, round sequencer and output register
//
// A 64-bit Feistel engine that keeps its 32-bit round keys in an 8192-entry
// single-port-write, synchronous-read table. A word with operation "load key"
// writes one table slot and gives no result. An encrypt or decrypt word runs
// min(round_count, 8192) rounds, one table read per cycle; its result is loaded
// into the output register once the last key word has come out of the table
// read register and the output register is free, and no new word is taken
// until then. A round count of zero passes the block through. Encryption uses
// keys 0 upward, decryption the same keys downward; the last round does not
// swap the halves. A finished result waits in the output register while the
// next word is taken. Slots must be loaded before a block reads them. The user
// must write round_count through i_cfg_we / i_cfg_wdata only while the engine
// is idle; the block does not enforce this. round_count resets to 8192.
module feistel_block_cipher_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration: round count
    input  logic                         i_cfg_we,
    input  logic [fbc_pkg::RC_W-1:0]     i_cfg_wdata,
    // input words
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // key_index[12:0], key_word[44:13], block_high[76:45], block_low[108:77], zero pad
    input  logic [fbc_pkg::S_DATA_W-1:0] s_axis_tdata,
    // operation[1:0]
    input  logic [fbc_pkg::OP_W-1:0]     s_axis_tuser,
    // result words
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // out_high[31:0], out_low[63:32]
    output logic [fbc_pkg::BLOCK_W-1:0]  m_axis_tdata
);
    import fbc_pkg::*;

    // round key table
    logic [HALF_W-1:0] r_key_mem [KEY_DEPTH];
    logic [HALF_W-1:0] r_rd_data;

    // control and datapath registers
    t_state            r_state, n_state;
    logic [RC_W-1:0]   r_round_count;
    logic [RC_W-1:0]   r_issue_left;
    logic [KEY_AW-1:0] r_slot;
    logic              r_dir_dec;
    logic              r_zero;
    logic              r_rd_valid;
    logic              r_rd_last;
    logic [HALF_W-1:0] r_left;
    logic [HALF_W-1:0] r_right;
    logic              r_out_valid;
    logic [BLOCK_W-1:0] r_out_data;

    // decoded input fields
    t_op               in_op;
    logic [IDX_W-1:0]  in_key_index;
    logic [HALF_W-1:0] in_key_word;
    logic [HALF_W-1:0] in_high;
    logic [HALF_W-1:0] in_low;

    logic [RC_W-1:0]   eff_rounds;
    logic              out_free;
    logic              rd_en;
    logic              finish;
    logic              key_we;
    logic              start;
    logic [HALF_W-1:0] mixed;

    assign in_op        = t_op'(s_axis_tuser);
    assign in_key_index = s_axis_tdata[IDX_LSB +: IDX_W];
    assign in_key_word  = s_axis_tdata[KEY_LSB +: HALF_W];
    assign in_high      = s_axis_tdata[HIGH_LSB +: HALF_W];
    assign in_low       = s_axis_tdata[LOW_LSB +: HALF_W];

    // round count saturates at the table depth
    assign eff_rounds = (r_round_count > RC_W'(KEY_DEPTH)) ? RC_W'(KEY_DEPTH) : r_round_count;

    assign out_free = !r_out_valid || m_axis_tready;
    assign mixed    = r_left ^ r_rd_data ^ r_right;

    // next state and control
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        finish        = 1'b0;
        key_we        = 1'b0;
        start         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    case (in_op)
                        OP_LOAD_KEY: key_we = 1'b1;
                        OP_ENCRYPT, OP_DECRYPT: begin
                            start   = 1'b1;
                            n_state = ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                rd_en = (r_issue_left != '0);
                if ((r_zero || (r_rd_valid && r_rd_last)) && out_free) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_round_count <= RC_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_round_count <= i_cfg_wdata;
            end
        end
    end

    // key table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[in_key_index] <= in_key_word;
        end
        if (rd_en) begin
            r_rd_data <= r_key_mem[r_slot];
        end
    end

    // round sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_left <= '0;
            r_rd_valid   <= 1'b0;
            r_rd_last    <= 1'b0;
            r_zero       <= 1'b0;
            r_dir_dec    <= 1'b0;
        end else if (start) begin
            r_issue_left <= eff_rounds;
            r_rd_valid   <= 1'b0;
            r_rd_last    <= 1'b0;
            r_zero       <= (eff_rounds == '0);
            r_dir_dec    <= (in_op == OP_DECRYPT);
        end else begin
            if (rd_en) begin
                r_issue_left <= r_issue_left - RC_W'(1);
                r_rd_last    <= (r_issue_left == RC_W'(1));
            end
            // the final key word is held until the output register is free
            r_rd_valid <= rd_en || (r_rd_valid && r_rd_last && !finish);
        end
    end

    // key slot walk and block halves
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_left  <= in_high;
            r_right <= in_low;
            r_slot  <= (in_op == OP_DECRYPT) ? KEY_AW'(eff_rounds - RC_W'(1)) : '0;
        end else begin
            if (rd_en) begin
                r_slot <= r_dir_dec ? (r_slot - KEY_AW'(1)) : (r_slot + KEY_AW'(1));
            end
            // swapping round
            if (r_rd_valid && !r_rd_last) begin
                r_right <= r_left;
                r_left  <= mixed;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_data <= r_zero ? {r_right, r_left} : {mixed, r_left};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // a new result only appears as the sequencer finishes a block
    a_out_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_RUN))
        else $error("result word appeared without a finished block");

    // key data only flows while a block is running
    a_rd_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (r_state == ST_RUN))
        else $error("key read data valid outside a run");

    // the last issued read comes back marked as last
    a_last_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_issue_left == RC_W'(1)) |=> (r_rd_valid && r_rd_last))
        else $error("last round key did not arrive");

    // a zero-round block issues no table reads
    a_zero_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_zero) |-> (r_issue_left == '0))
        else $error("zero-round block is reading keys");
`endif

endmodule

// ----- verif/testbench.sv -----
// testbench for the feistel block cipher engine: scoreboard, word drivers and checks
`timescale 1ns / 1ps

module testbench;
    import fbc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;
    localparam int              KEY_SLOTS     = 32;
    localparam int              CLK_HALF      = 10;
    localparam int              RESET_CYCLES  = 6;
    localparam int              CYCLE_LIMIT   = 1_000_000;
    localparam int              IDLE_PCT      = 6;
    localparam int              SETTLE_CYCLES = 8;
    localparam int              RANDOM_PHASES = 6;
    localparam int              QUIET_PHASE   = 2;
    localparam int              LONG_PHASE    = 4;

    // expected cipher results, with a private copy of the key table and round count
    class cipher_scoreboard;
        logic [HALF_W-1:0]  round_keys [KEY_DEPTH];
        logic [RC_W-1:0]    round_count;
        logic [BLOCK_W-1:0] expected_blocks [$];
        int unsigned        mismatches;
        int unsigned        blocks_seen;
        int unsigned        keys_loaded;
        int unsigned        words_ignored;

        function new();
            round_count   = RC_RESET;
            mismatches    = 0;
            blocks_seen   = 0;
            keys_loaded   = 0;
            words_ignored = 0;
        endfunction

        // register value saturates at the table depth
        function int unsigned active_rounds();
            return (round_count > KEY_DEPTH) ? KEY_DEPTH : int'(round_count);
        endfunction

        // feistel rounds, last one unswapped; packed as out_low, out_high
        function logic [BLOCK_W-1:0] cipher_block(input logic [HALF_W-1:0] hi,
                                                  input logic [HALF_W-1:0] lo,
                                                  input bit backward);
            int unsigned       rounds;
            int unsigned       slot;
            logic [HALF_W-1:0] lft;
            logic [HALF_W-1:0] rgt;
            logic [HALF_W-1:0] mixed;
            rounds = active_rounds();
            lft    = hi;
            rgt    = lo;
            for (int unsigned i = 0; i < rounds; i++) begin
                slot  = backward ? rounds - 1 - i : i;
                mixed = lft ^ round_keys[slot] ^ rgt;
                if (i == rounds - 1) begin
                    rgt = mixed;
                end else begin
                    rgt = lft;
                    lft = mixed;
                end
            end
            return {rgt, lft};
        endfunction

        // accepted input word: update the key table, queue a result or count an unused op
        function void note_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic [HALF_W-1:0] word,
                                input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo);
            case (op)
                OP_LOAD_KEY: begin
                    if (idx < KEY_DEPTH) round_keys[idx] = word;
                    keys_loaded++;
                end
                OP_ENCRYPT: expected_blocks.insert(expected_blocks.size(),
                                                   cipher_block(hi, lo, 1'b0));
                OP_DECRYPT: expected_blocks.insert(expected_blocks.size(),
                                                   cipher_block(hi, lo, 1'b1));
                default: words_ignored++;
            endcase
        endfunction

        task report_mismatch(input string what, input logic [HALF_W-1:0] want,
                             input logic [HALF_W-1:0] got);
            mismatches++;
            $display("mismatch at %0t ns: %s expected %h got %h", $time, what, want, got);
        endtask

        // accepted result word against the oldest expectation
        task check_block(input logic [BLOCK_W-1:0] got);
            logic [BLOCK_W-1:0] want;
            if (expected_blocks.size() == 0) begin
                report_mismatch("result with none pending, out_high", '0, got[HALF_W-1:0]);
            end else begin
                want = expected_blocks.pop_front();
                blocks_seen++;
                if (got[HALF_W-1:0] !== want[HALF_W-1:0])
                    report_mismatch("out_high", want[HALF_W-1:0], got[HALF_W-1:0]);
                if (got[BLOCK_W-1:HALF_W] !== want[BLOCK_W-1:HALF_W])
                    report_mismatch("out_low", want[BLOCK_W-1:HALF_W], got[BLOCK_W-1:HALF_W]);
            end
        endtask
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [RC_W-1:0]       i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [OP_W-1:0]       s_axis_tuser  = OP_LOAD_KEY;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [BLOCK_W-1:0]    m_axis_tdata;

    cipher_scoreboard      cipher_sb;
    bit                    src_idle_en   = 1'b0;
    bit                    sink_idle_en  = 1'b0;
    int unsigned           cycle_count   = 0;
    int unsigned           settings_used = 0;

    feistel_block_cipher_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("feistel_block_cipher_top verification failed");
            $finish;
        end
    end

    // result side: check accepted words, stall now and then
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            cipher_sb.check_block(m_axis_tdata);
        if (sink_idle_en && $urandom_range(99) < IDLE_PCT) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // present one input word and hold it until taken
    task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [HALF_W-1:0] word,
                             input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo);
        logic [S_DATA_W-1:0] data_word;
        data_word                       = '0;
        data_word[IDX_LSB +: IDX_W]     = idx;
        data_word[KEY_LSB +: HALF_W]    = word;
        data_word[HIGH_LSB +: HALF_W]   = hi;
        data_word[LOW_LSB +: HALF_W]    = lo;
        if (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data_word;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        cipher_sb.note_word(op, idx, word, hi, lo);
    endtask

    task automatic load_key(input logic [IDX_W-1:0] idx, input logic [HALF_W-1:0] word);
        send_word(OP_LOAD_KEY, idx, word, $urandom, $urandom);
    endtask

    task automatic send_block(input logic [OP_W-1:0] op, input logic [HALF_W-1:0] hi,
                              input logic [HALF_W-1:0] lo);
        send_word(op, IDX_W'($urandom), $urandom, hi, lo);
    endtask

    // mostly cipher blocks, some key rewrites, a few unused-operation words
    task automatic send_random_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
            load_key(IDX_W'($urandom), $urandom);
        else if (pick < 20)
            send_word(OP_UNUSED, IDX_W'($urandom), $urandom, $urandom, $urandom);
        else if (pick < 60)
            send_block(OP_ENCRYPT, $urandom, $urandom);
        else
            send_block(OP_DECRYPT, $urandom, $urandom);
    endtask

    // round count write once the engine has drained
    task automatic set_round_count(input logic [RC_W-1:0] count);
        s_axis_tvalid <= 1'b0;
        while (cipher_sb.expected_blocks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cipher_sb.round_count = count;
        settings_used++;
    endtask

    initial begin
        int unsigned     items;
        logic [RC_W-1:0] count;
        cipher_sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // low key slots first, no idling; round counts never reach past them
        for (int k = 0; k < KEY_SLOTS; k++)
            load_key(IDX_W'(k), $urandom);

        // directed: key extremes over every loaded slot
        set_round_count(RC_W'(KEY_SLOTS));
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        load_key('0, '1);
        load_key(IDX_W'(KEY_SLOTS - 1), '0);
        load_key(IDX_W'(1), '0);
        send_block(OP_ENCRYPT, '0, '0);
        send_block(OP_DECRYPT, '1, '1);
        send_word(OP_UNUSED, '1, '1, '1, '1);

        // zero rounds pass the block through
        set_round_count('0);
        send_block(OP_ENCRYPT, '1, '0);
        send_block(OP_DECRYPT, '0, '1);

        // single unswapped round, then two rounds
        set_round_count(RC_W'(1));
        send_block(OP_ENCRYPT, '1, '1);
        send_block(OP_DECRYPT, '0, '0);
        set_round_count(RC_W'(2));
        send_block(OP_ENCRYPT, '1, '0);
        send_block(OP_DECRYPT, '0, '1);

        // random phases, mostly short round counts, one over every loaded slot
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            src_idle_en  = (phase != QUIET_PHASE);
            sink_idle_en = (phase != QUIET_PHASE);
            if (phase == LONG_PHASE) begin
                count = RC_W'(KEY_SLOTS);
                items = 4;
            end else begin
                count = RC_W'($urandom_range(1, 24));
                items = 10;
            end
            set_round_count(count);
            repeat (items) send_random_word();
        end

        // drain outstanding results, then a little more for stray words
        s_axis_tvalid <= 1'b0;
        while (cipher_sb.expected_blocks.size() != 0) @(posedge i_clk);
        repeat (cipher_sb.active_rounds() + 16) @(posedge i_clk);

        $display("covered %0d key loads, %0d checked cipher blocks, %0d unused-op words",
                 cipher_sb.keys_loaded, cipher_sb.blocks_seen, cipher_sb.words_ignored);
        $display("round counts: %0d written settings incl. 0, 1, 2 and %0d rounds",
                 settings_used, KEY_SLOTS);
        if (cipher_sb.mismatches == 0) begin
            $display("feistel_block_cipher_top verification clean");
        end else begin
            $display("feistel_block_cipher_top verification failed");
        end
        $finish;
    end

endmodule
